>>> hw/rtl/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, fixed-point coefficients and per-channel arithmetic for the
// YUYV to RGB24 conversion pipeline.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int COEF_FRAC_BITS = 16;

    // coefficients are below 2.0, so one integer bit is enough
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    // signed coefficient times signed 9-bit chroma offset
    localparam int PROD_W = COEF_FRAC_BITS + 11;
    // luma at the coefficient scale plus up to two products
    localparam int SUM_W  = COEF_FRAC_BITS + 13;

    localparam int GAIN_W = 9;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(220);

    localparam longint unsigned MICRO     = 64'd1000000;
    localparam longint unsigned COEF_ONE  = 64'd1 << COEF_FRAC_BITS;
    localparam longint unsigned COEF_HALF = MICRO / 64'd2;

    localparam logic [COEF_W-1:0] K_RV =
        COEF_W'((64'd1370705 * COEF_ONE + COEF_HALF) / MICRO);
    localparam logic [COEF_W-1:0] K_GV =
        COEF_W'((64'd698001 * COEF_ONE + COEF_HALF) / MICRO);
    localparam logic [COEF_W-1:0] K_GU =
        COEF_W'((64'd337633 * COEF_ONE + COEF_HALF) / MICRO);
    localparam logic [COEF_W-1:0] K_BU =
        COEF_W'((64'd1732446 * COEF_ONE + COEF_HALF) / MICRO);

    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    typedef struct packed {
        logic signed [PROD_W-1:0] rv;
        logic signed [PROD_W-1:0] gv;
        logic signed [PROD_W-1:0] gu;
        logic signed [PROD_W-1:0] bu;
    } prod_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        prod_t      prod;
        logic       frame_end;
    } s1_word_t;

    typedef struct packed {
        rgb_t p0;
        rgb_t p1;
        logic frame_end;
    } s2_word_t;

    // floor is the drop of the fraction bits, then clamp to 0..255
    function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] s);
        logic [7:0] c;
        if (s[SUM_W-1])
        begin
            c = 8'd0;
        end
        else if (|s[SUM_W-2:COEF_FRAC_BITS+8])
        begin
            c = 8'd255;
        end
        else
        begin
            c = s[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return c;
    endfunction

    function automatic rgb_t to_rgb(input logic [7:0] y, input prod_t p);
        logic signed [SUM_W-1:0] base;
        logic signed [SUM_W-1:0] r_sum;
        logic signed [SUM_W-1:0] g_sum;
        logic signed [SUM_W-1:0] b_sum;
        rgb_t                    px;
        base  = $signed({{(SUM_W-COEF_FRAC_BITS-8){1'b0}}, y, {COEF_FRAC_BITS{1'b0}}});
        r_sum = base + SUM_W'(p.rv);
        g_sum = base - SUM_W'(p.gv) - SUM_W'(p.gu);
        b_sum = base + SUM_W'(p.bu);
        px.r  = clamp_sum(r_sum);
        px.g  = clamp_sum(g_sum);
        px.b  = clamp_sum(b_sum);
        return px;
    endfunction

    // c * gain / 256, saturated to 255
    function automatic logic [7:0] apply_gain(input logic [7:0] c,
                                              input logic [GAIN_W-1:0] gain);
        logic [GAIN_W+7:0] scaled;
        logic [7:0]        s;
        scaled = {{GAIN_W{1'b0}}, c} * {8'd0, gain};
        if (|scaled[GAIN_W+7:16])
        begin
            s = 8'd255;
        end
        else
        begin
            s = scaled[15:8];
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/y2r_chroma_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma_stage
// First pipeline stage: removes the chroma offset and forms the four
// coefficient products shared by both pixels of a word.
// ----------------------------------------------------------------------------
module y2r_chroma_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          first_luma,
    input  logic [7:0]          chroma_blue,
    input  logic [7:0]          second_luma,
    input  logic [7:0]          chroma_red,
    input  logic                frame_end,
    output logic                out_valid,
    input  logic                out_ready,
    output y2r_pkg::s1_word_t   out_word
);
    import y2r_pkg::*;

    localparam logic signed [PROD_W-1:0] K_RV_S = PROD_W'($signed({1'b0, K_RV}));
    localparam logic signed [PROD_W-1:0] K_GV_S = PROD_W'($signed({1'b0, K_GV}));
    localparam logic signed [PROD_W-1:0] K_GU_S = PROD_W'($signed({1'b0, K_GU}));
    localparam logic signed [PROD_W-1:0] K_BU_S = PROD_W'($signed({1'b0, K_BU}));

    logic              valid_reg;
    logic              valid_next;
    s1_word_t          word_reg;
    s1_word_t          word_next;
    logic signed [8:0] du;
    logic signed [8:0] dv;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        du                  = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
        dv                  = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
        word_next.y0        = first_luma;
        word_next.y1        = second_luma;
        word_next.frame_end = frame_end;
        word_next.prod.rv   = K_RV_S * PROD_W'(dv);
        word_next.prod.gv   = K_GV_S * PROD_W'(dv);
        word_next.prod.gu   = K_GU_S * PROD_W'(du);
        word_next.prod.bu   = K_BU_S * PROD_W'(du);
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hw/rtl/y2r_pixel_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pixel_stage
// Second pipeline stage: adds luma to the chroma products for both pixels,
// floors each sum and clamps it to a byte.
// ----------------------------------------------------------------------------
module y2r_pixel_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  y2r_pkg::s1_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output y2r_pkg::s2_word_t   out_word
);
    import y2r_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    s2_word_t word_reg;
    s2_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next.p0        = to_rgb(in_word.y0, in_word.prod);
        word_next.p1        = to_rgb(in_word.y1, in_word.prod);
        word_next.frame_end = in_word.frame_end;
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hw/rtl/y2r_gain_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_gain_stage
// Last pipeline stage and output register: scales the six colour bytes by
// the output gain over 256 and holds the word until it is taken.
// ----------------------------------------------------------------------------
module y2r_gain_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [y2r_pkg::GAIN_W-1:0]  gain,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  y2r_pkg::s2_word_t           in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output y2r_pkg::s2_word_t           out_word
);
    import y2r_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    s2_word_t word_reg;
    s2_word_t word_next;

    assign in_ready = !valid_reg || !out_stall;

    always_comb
    begin
        word_next.p0.r      = apply_gain(in_word.p0.r, gain);
        word_next.p0.g      = apply_gain(in_word.p0.g, gain);
        word_next.p0.b      = apply_gain(in_word.p0.b, gain);
        word_next.p1.r      = apply_gain(in_word.p1.r, gain);
        word_next.p1.g      = apply_gain(in_word.p1.g, gain);
        word_next.p1.b      = apply_gain(in_word.p1.b, gain);
        word_next.frame_end = in_word.frame_end;
        valid_next          = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hw/rtl/yuyv_to_rgb24_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb24_converter
// Converts one packed YUYV word into two RGB888 pixels with clamping and an
// output gain, as a three-stage pipeline.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     first_luma chroma_blue second_luma
//                                     chroma_red frame_end
//   output    out_valid / out_stall   first/second red green blue,
//                                     frame_end_out
//   config    output_gain_wr          output_gain (9 bits)
//
// one word per clock sustained while the output is not stalled; the chroma
// multipliers, the sum and clamp adders and the gain multipliers each have a register
// reset clears the stage valid bits and loads the gain with 220
// stalls back up stage by stage; empty stages keep accepting, so a stalled
// output still leaves room for up to two more words upstream
// ----------------------------------------------------------------------------
module yuyv_to_rgb24_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        output_gain_wr,
    input  logic [8:0]  output_gain,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  first_luma,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  second_luma,
    input  logic [7:0]  chroma_red,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  first_red,
    output logic [7:0]  first_green,
    output logic [7:0]  first_blue,
    output logic [7:0]  second_red,
    output logic [7:0]  second_green,
    output logic [7:0]  second_blue,
    output logic        frame_end_out
);
    import y2r_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic              in_ready;
    logic              s1_valid;
    logic              s1_ready;
    s1_word_t          s1_word;
    logic              s2_valid;
    logic              s2_ready;
    s2_word_t          s2_word;
    s2_word_t          out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (output_gain_wr)
        begin
            gain_reg <= output_gain;
        end
    end

    y2r_chroma_stage u_chroma (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_luma  (first_luma),
        .chroma_blue (chroma_blue),
        .second_luma (second_luma),
        .chroma_red  (chroma_red),
        .frame_end   (frame_end),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_word    (s1_word)
    );

    y2r_pixel_stage u_pixel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    y2r_gain_stage u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign in_stall      = !in_ready;
    assign first_red     = out_word.p0.r;
    assign first_green   = out_word.p0.g;
    assign first_blue    = out_word.p0.b;
    assign second_red    = out_word.p1.r;
    assign second_green  = out_word.p1.g;
    assign second_blue   = out_word.p1.b;
    assign frame_end_out = out_word.frame_end;

    // a free output slot lets the whole pipe move
    a_no_stall_when_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall
    ) else $error("input stalled while the output drains");

    // input only stalls when every stage holds a word
    a_stall_means_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid)
    ) else $error("input stalled with an empty stage");

    // a held output word stays in place
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && out_word == $past(out_word))
    ) else $error("stalled output word lost or changed");

    // gain write takes effect on the next cycle
    a_gain_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        output_gain_wr |=> (gain_reg == $past(output_gain))
    ) else $error("gain register not updated");

endmodule
